/* rtl/ise_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_pkg: shared definitions for the indexed stack engine
// Store geometry, request codes, status codes and the walk plan record that
// the request decoder hands to the sequencer.
// ----------------------------------------------------------------------------
package ise_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = 6;
    localparam int CNT_W   = 7;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    // Register indexes (byte address 4*index)
    localparam logic REG_CAPACITY = 1'b0;

    // Request codes
    localparam logic [3:0] FN_PUSH         = 4'd0;
    localparam logic [3:0] FN_PUSH_BOTTOM  = 4'd1;
    localparam logic [3:0] FN_INSERT_AT    = 4'd2;
    localparam logic [3:0] FN_POP          = 4'd3;
    localparam logic [3:0] FN_REMOVE_BOTTOM = 4'd4;
    localparam logic [3:0] FN_REMOVE_AT    = 4'd5;
    localparam logic [3:0] FN_REMOVE_VALUE = 4'd6;
    localparam logic [3:0] FN_PEEK_TOP     = 4'd7;
    localparam logic [3:0] FN_PEEK_BOTTOM  = 4'd8;
    localparam logic [3:0] FN_PEEK_AT      = 4'd9;
    localparam logic [3:0] FN_FIND_FIRST   = 4'd10;
    localparam logic [3:0] FN_FIND_LAST    = 4'd11;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd3;

    // Kind of store walk a request needs
    typedef enum logic [2:0] {
        WK_NONE,
        WK_WRITE,
        WK_SHIFT_UP,
        WK_SHIFT_DOWN,
        WK_FILTER,
        WK_READ,
        WK_FIND_FIRST,
        WK_FIND_LAST
    } walk_t;

    typedef struct packed {
        logic [1:0]       status;
        walk_t            walk;
        logic [CNT_W-1:0] at;
        logic             pop;
        logic             find;
    } plan_t;

endpackage

/* rtl/indexed_stack_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_stack_engine: bounded stack of signed words with indexed access
// Push, insert, pop, remove, filter, peek and search over a 64-entry store,
// one request at a time, one result per request.
// ----------------------------------------------------------------------------
// A request is decoded in the cycle it is taken; then a sequencer walks the
// entry store through its single read port and single write port, one entry
// per cycle, with the read data registered. A request that reads entries, at
// most DEPTH of them (shift for insert or remove, the filter pass of remove
// value, a search up to its hit, or the single read of pop and peek), issues
// one read per entry and commits any fill level change when the walk is over.
// Requests settled at decode (plain push, full, empty, bad index, unused
// codes) skip the walk; removing the top entry reads nothing. Every result
// is held in the sequencer until the output register is free, and the next
// request is taken only once the result has moved there. The input channel
// is ready whenever the sequencer is idle, even while an earlier result is
// still waiting in the output register. The capacity register is written
// through the APB port at byte address 0 and should only be changed while
// idle; values above the store depth act as the depth. The store has no
// reset; only entries below the fill level are ever read.
// ----------------------------------------------------------------------------
module indexed_stack_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [3:0]                    s_func,
    input  logic signed [31:0]            s_value,
    input  logic [5:0]                    s_index,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic signed [31:0]            m_data,
    output logic signed [6:0]             m_position,
    output logic                          m_found,
    output logic [6:0]                    m_removed_count,
    output logic [6:0]                    m_occupancy,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ise_pkg::PADDR_W-1:0]   paddr,
    input  logic [ise_pkg::PDATA_W-1:0]   pwdata,
    output logic [ise_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } state_t;

    localparam int AW = ise_pkg::ADDR_W;
    localparam int CW = ise_pkg::CNT_W;
    localparam int DW = ise_pkg::DATA_W;

    // Sequencer state
    state_t                state_reg, state_next;
    ise_pkg::walk_t        walk_reg, walk_next;
    logic [DW-1:0]         val_reg, val_next;
    logic [AW-1:0]         at_reg, at_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]         left_reg, left_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_addr_reg, pend_addr_next;
    logic [CW-1:0]         keep_reg, keep_next;
    logic                  hit_reg, hit_next;
    logic                  pop_reg, pop_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic [CW-1:0]         cap_reg;

    // Result being built
    logic [1:0]            res_status_reg, res_status_next;
    logic [DW-1:0]         res_data_reg, res_data_next;
    logic [CW-1:0]         res_pos_reg, res_pos_next;
    logic                  res_found_reg, res_found_next;
    logic [CW-1:0]         res_removed_reg, res_removed_next;

    // Output register
    logic                  m_valid_reg, m_valid_next;
    logic [1:0]            m_status_reg, m_status_next;
    logic [DW-1:0]         m_data_reg, m_data_next;
    logic [CW-1:0]         m_pos_reg, m_pos_next;
    logic                  m_found_reg, m_found_next;
    logic [CW-1:0]         m_removed_reg, m_removed_next;
    logic [CW-1:0]         m_occ_reg, m_occ_next;

    // Entry store
    logic [DW-1:0]         mem [0:ise_pkg::DEPTH-1];
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DW-1:0]         mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [DW-1:0]         mem_rdata_reg;

    ise_pkg::plan_t        plan;
    logic                  accept;
    logic                  issue;
    logic                  hit_now;
    logic                  is_find;
    logic                  descending;
    logic                  cfg_write;

    ise_plan u_plan (
        .func  (s_func),
        .index (s_index),
        .fill  (fill_reg),
        .cap   (cap_reg),
        .plan  (plan)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    // Configuration port: capacity is the only register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == ise_pkg::REG_CAPACITY) ?
                       {{(ise_pkg::PDATA_W-CW){1'b0}}, cap_reg} : '0;

    assign is_find    = (walk_reg == ise_pkg::WK_FIND_FIRST) ||
                        (walk_reg == ise_pkg::WK_FIND_LAST);
    assign descending = (walk_reg == ise_pkg::WK_SHIFT_UP) ||
                        (walk_reg == ise_pkg::WK_FIND_LAST);
    assign hit_now    = pend_reg && is_find && !hit_reg && (mem_rdata_reg == val_reg);
    // Stop issuing reads once the walk is exhausted or a search has hit
    assign issue      = (state_reg == S_WALK) && (left_reg != '0) && !hit_reg && !hit_now;

    always_comb begin
        state_next       = state_reg;
        walk_next        = walk_reg;
        val_next         = val_reg;
        at_next          = at_reg;
        rd_ptr_next      = rd_ptr_reg;
        left_next        = left_reg;
        pend_next        = 1'b0;
        pend_addr_next   = pend_addr_reg;
        keep_next        = keep_reg;
        hit_next         = hit_reg;
        pop_next         = pop_reg;
        fill_next        = fill_reg;
        res_status_next  = res_status_reg;
        res_data_next    = res_data_reg;
        res_pos_next     = res_pos_reg;
        res_found_next   = res_found_reg;
        res_removed_next = res_removed_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_data_next      = m_data_reg;
        m_pos_next       = m_pos_reg;
        m_found_next     = m_found_reg;
        m_removed_next   = m_removed_reg;
        m_occ_next       = m_occ_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_raddr        = rd_ptr_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    // latch the request and set up the walk
                    walk_next        = plan.walk;
                    val_next         = s_value;
                    at_next          = plan.at[AW-1:0];
                    pop_next         = plan.pop;
                    hit_next         = 1'b0;
                    keep_next        = '0;
                    res_status_next  = plan.status;
                    res_data_next    = '0;
                    res_pos_next     = plan.find ? '1 : '0;
                    res_found_next   = 1'b0;
                    res_removed_next = '0;
                    state_next       = S_WALK;
                    case (plan.walk)
                        ise_pkg::WK_NONE: begin
                            state_next = S_DONE;
                        end
                        ise_pkg::WK_WRITE: begin
                            mem_we     = 1'b1;
                            mem_waddr  = plan.at[AW-1:0];
                            mem_wdata  = s_value;
                            fill_next  = fill_reg + CW'(1);
                            state_next = S_DONE;
                        end
                        ise_pkg::WK_SHIFT_UP: begin
                            rd_ptr_next = AW'(fill_reg - CW'(1));
                            left_next   = fill_reg - plan.at;
                        end
                        ise_pkg::WK_SHIFT_DOWN: begin
                            rd_ptr_next = AW'(plan.at + CW'(1));
                            left_next   = fill_reg - CW'(1) - plan.at;
                        end
                        ise_pkg::WK_FILTER, ise_pkg::WK_FIND_FIRST: begin
                            rd_ptr_next = '0;
                            left_next   = fill_reg;
                        end
                        ise_pkg::WK_FIND_LAST: begin
                            rd_ptr_next = AW'(fill_reg - CW'(1));
                            left_next   = fill_reg;
                        end
                        ise_pkg::WK_READ: begin
                            rd_ptr_next = plan.at[AW-1:0];
                            left_next   = CW'(1);
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_WALK: begin
                // issue one read per cycle
                if (issue) begin
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_reg;
                    rd_ptr_next    = descending ? rd_ptr_reg - AW'(1) : rd_ptr_reg + AW'(1);
                    left_next      = left_reg - CW'(1);
                end
                // consume the read issued last cycle
                if (pend_reg) begin
                    case (walk_reg)
                        ise_pkg::WK_SHIFT_UP: begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg + AW'(1);
                            mem_wdata = mem_rdata_reg;
                        end
                        ise_pkg::WK_SHIFT_DOWN: begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg - AW'(1);
                            mem_wdata = mem_rdata_reg;
                        end
                        ise_pkg::WK_FILTER: begin
                            if (mem_rdata_reg != val_reg) begin
                                mem_we    = 1'b1;
                                mem_waddr = keep_reg[AW-1:0];
                                mem_wdata = mem_rdata_reg;
                                keep_next = keep_reg + CW'(1);
                            end
                        end
                        ise_pkg::WK_READ: begin
                            res_data_next = mem_rdata_reg;
                        end
                        ise_pkg::WK_FIND_FIRST, ise_pkg::WK_FIND_LAST: begin
                            if (hit_now) begin
                                hit_next       = 1'b1;
                                res_found_next = 1'b1;
                                res_pos_next   = {1'b0, pend_addr_reg};
                            end
                        end
                        default: begin
                            mem_we = 1'b0;
                        end
                    endcase
                end
                // walk over: commit the fill level change
                if (!issue && !pend_reg) begin
                    state_next = S_DONE;
                    case (walk_reg)
                        ise_pkg::WK_SHIFT_UP: begin
                            mem_we    = 1'b1;
                            mem_waddr = at_reg;
                            mem_wdata = val_reg;
                            fill_next = fill_reg + CW'(1);
                        end
                        ise_pkg::WK_SHIFT_DOWN: begin
                            fill_next = fill_reg - CW'(1);
                        end
                        ise_pkg::WK_FILTER: begin
                            res_removed_next = fill_reg - keep_reg;
                            fill_next        = keep_reg;
                        end
                        ise_pkg::WK_READ: begin
                            if (pop_reg) begin
                                fill_next = fill_reg - CW'(1);
                            end
                        end
                        default: begin
                            fill_next = fill_reg;
                        end
                    endcase
                end
            end

            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_data_next    = res_data_reg;
                    m_pos_next     = res_pos_reg;
                    m_found_next   = res_found_reg;
                    m_removed_next = res_removed_reg;
                    m_occ_next     = fill_reg;
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            cap_reg     <= ise_pkg::CAP_RESET;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            pend_reg    <= pend_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
            if (cfg_write && (paddr[2] == ise_pkg::REG_CAPACITY)) begin
                cap_reg <= pwdata[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg        <= walk_next;
        val_reg         <= val_next;
        at_reg          <= at_next;
        rd_ptr_reg      <= rd_ptr_next;
        left_reg        <= left_next;
        pend_addr_reg   <= pend_addr_next;
        keep_reg        <= keep_next;
        pop_reg         <= pop_next;
        res_status_reg  <= res_status_next;
        res_data_reg    <= res_data_next;
        res_pos_reg     <= res_pos_next;
        res_found_reg   <= res_found_next;
        res_removed_reg <= res_removed_next;
        m_status_reg    <= m_status_next;
        m_data_reg      <= m_data_next;
        m_pos_reg       <= m_pos_next;
        m_found_reg     <= m_found_next;
        m_removed_reg   <= m_removed_next;
        m_occ_reg       <= m_occ_next;
    end

    // Entry store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_data          = $signed(m_data_reg);
    assign m_position      = $signed(m_pos_reg);
    assign m_found         = m_found_reg;
    assign m_removed_count = m_removed_reg;
    assign m_occupancy     = m_occ_reg;

    // Fill level never exceeds the store depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(ise_pkg::DEPTH))
        else $error("fill level above store depth");

    // A read is only in flight while walking
    a_pend_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == S_WALK))
        else $error("store read pending outside a walk");

    // Fill level moves only on an accepted request or at the end of a walk
    a_fill_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg != S_WALK) && !accept) |=> $stable(fill_reg))
        else $error("fill level changed while quiet");

    // A push refused as full leaves the fill level alone
    a_full_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (plan.status == ise_pkg::STAT_FULL)) |=>
            (fill_reg == $past(fill_reg)))
        else $error("refused push changed the fill level");

endmodule

/* rtl/ise_plan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_plan: request decoder
// Checks a request against the fill level and capacity, picks its status and
// the store walk that carries it out.
// ----------------------------------------------------------------------------
module ise_plan (
    input  logic [3:0]                 func,
    input  logic [ise_pkg::ADDR_W-1:0] index,
    input  logic [ise_pkg::CNT_W-1:0]  fill,
    input  logic [ise_pkg::CNT_W-1:0]  cap,
    output ise_pkg::plan_t             plan
);

    logic [ise_pkg::CNT_W-1:0] eff_cap;
    logic [ise_pkg::CNT_W-1:0] idx_ext;
    logic [ise_pkg::CNT_W-1:0] top_pos;
    logic                      full;
    logic                      empty;

    assign eff_cap = (cap > ise_pkg::CNT_W'(ise_pkg::DEPTH)) ?
                     ise_pkg::CNT_W'(ise_pkg::DEPTH) : cap;
    assign idx_ext = {1'b0, index};
    assign top_pos = fill - ise_pkg::CNT_W'(1);
    assign full    = fill >= eff_cap;
    assign empty   = fill == '0;

    always_comb begin
        plan        = '0;
        plan.status = ise_pkg::STAT_OK;
        plan.walk   = ise_pkg::WK_NONE;
        case (func)
            ise_pkg::FN_PUSH, ise_pkg::FN_PUSH_BOTTOM, ise_pkg::FN_INSERT_AT: begin
                if (func == ise_pkg::FN_PUSH) begin
                    plan.at = fill;
                end else if (func == ise_pkg::FN_PUSH_BOTTOM) begin
                    plan.at = '0;
                end else begin
                    plan.at = idx_ext;
                end
                if (full) begin
                    plan.status = ise_pkg::STAT_FULL;
                end else if (plan.at > fill) begin
                    plan.status = ise_pkg::STAT_BAD_INDEX;
                end else if (plan.at == fill) begin
                    plan.walk = ise_pkg::WK_WRITE;
                end else begin
                    plan.walk = ise_pkg::WK_SHIFT_UP;
                end
            end
            ise_pkg::FN_POP: begin
                plan.at = top_pos;
                if (empty) begin
                    plan.status = ise_pkg::STAT_EMPTY;
                end else begin
                    plan.walk = ise_pkg::WK_READ;
                    plan.pop  = 1'b1;
                end
            end
            ise_pkg::FN_REMOVE_BOTTOM, ise_pkg::FN_REMOVE_AT: begin
                plan.at = (func == ise_pkg::FN_REMOVE_BOTTOM) ? '0 : idx_ext;
                if (empty) begin
                    plan.status = ise_pkg::STAT_EMPTY;
                end else if (plan.at >= fill) begin
                    plan.status = ise_pkg::STAT_BAD_INDEX;
                end else begin
                    plan.walk = ise_pkg::WK_SHIFT_DOWN;
                end
            end
            ise_pkg::FN_REMOVE_VALUE: begin
                if (!empty) begin
                    plan.walk = ise_pkg::WK_FILTER;
                end
            end
            ise_pkg::FN_PEEK_TOP, ise_pkg::FN_PEEK_BOTTOM, ise_pkg::FN_PEEK_AT: begin
                if (func == ise_pkg::FN_PEEK_TOP) begin
                    plan.at = top_pos;
                end else if (func == ise_pkg::FN_PEEK_BOTTOM) begin
                    plan.at = '0;
                end else begin
                    plan.at = idx_ext;
                end
                if (empty) begin
                    plan.status = ise_pkg::STAT_EMPTY;
                end else if (plan.at >= fill) begin
                    plan.status = ise_pkg::STAT_BAD_INDEX;
                end else begin
                    plan.walk = ise_pkg::WK_READ;
                end
            end
            ise_pkg::FN_FIND_FIRST, ise_pkg::FN_FIND_LAST: begin
                plan.find = 1'b1;
                if (!empty) begin
                    plan.walk = (func == ise_pkg::FN_FIND_FIRST) ?
                                ise_pkg::WK_FIND_FIRST : ise_pkg::WK_FIND_LAST;
                end
            end
            default: begin
                plan.walk = ise_pkg::WK_NONE;
            end
        endcase
    end

endmodule
